>>> rtl/bdq_pkg.sv
// Package for the bounded deque unit: sizes, operation and status codes,
// controller states, command/status structs and ring index helpers.
// No dependencies.
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_DELETE     = 3'd4,
    MODE_CLEAR      = 3'd5,
    MODE_DUMP       = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DUMP_RD,
    S_DUMP_EMIT,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {FR_HOLD, FR_DEC, FR_INC, FR_CLR} front_op_t;
  typedef enum logic [1:0] {CT_HOLD, CT_INC, CT_DEC, CT_CLR} cnt_op_t;
  typedef enum logic [1:0] {WR_FRONT, WR_BACK, WR_SHIFT} wr_sel_t;
  typedef enum logic       {RD_POS, RD_NEXT} rd_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      ld_op;
    logic      pos_clr;
    logic      pos_inc;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    front_op_t front_op;
    cnt_op_t   cnt_op;
    logic      emit;
    logic      emit_dump;
    status_t   emit_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  full;
    logic  match;
    logic  pos_zero;
    logic  pos_last;
    logic  out_free;
  } stat_t;

  // (base + off) mod CAPACITY, off < CAPACITY
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
    logic [IDX_W-1:0] res;
    if (base == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

>>> rtl/bdq_in_if.sv
// Request channel interface: valid/ready plus operation and value.
// Depends on bdq_pkg.
interface bdq_in_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          mode;
  logic signed [bdq_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

>>> rtl/bdq_out_if.sv
// Result channel interface: valid/ready plus status, item, count, last.
// Depends on bdq_pkg.
interface bdq_out_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [bdq_pkg::DATA_W-1:0]   item;
  logic [bdq_pkg::CNT_W-1:0]           count;
  logic                                last;

  modport source (output valid, output status, output item, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input item, input count,
                  input last, output ready);
endinterface

>>> rtl/bdq_dp.sv
// Datapath: entry memory, front/count/position registers, request capture
// and the result register. Depends on bdq_pkg.
module bdq_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bdq_pkg::cmd_t                       cmd,
  output bdq_pkg::stat_t                      stat,
  input  logic [2:0]                          in_mode,
  input  logic signed [bdq_pkg::DATA_W-1:0]   in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]   out_item,
  output logic [bdq_pkg::CNT_W-1:0]           out_count,
  output logic                                out_last
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic [2:0]        mode_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  pos_ext, pos_p1;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic              ovalid_r, ovalid_nxt;
  logic [1:0]        ostatus_r;
  logic [DATA_W-1:0] oitem_r;
  logic [CNT_W-1:0]  ocount_r;
  logic              olast_r;

  assign pos_ext = CNT_W'(pos_r);
  assign pos_p1  = pos_ext + 1'b1;

  assign rd_addr = (cmd.rd_sel == RD_NEXT) ? ring_add(front_r, pos_p1)
                                           : ring_add(front_r, pos_ext);

  always_comb begin
    case (cmd.wr_sel)
      WR_FRONT: wr_addr = ring_dec(front_r);
      WR_BACK:  wr_addr = ring_add(front_r, count_r);
      default:  wr_addr = ring_add(front_r, pos_ext);
    endcase
  end
  assign wr_data = (cmd.wr_sel == WR_SHIFT) ? rd_data_r : val_r;

  always_comb begin
    case (cmd.front_op)
      FR_DEC:  front_nxt = ring_dec(front_r);
      FR_INC:  front_nxt = ring_add(front_r, CNT_W'(1));
      FR_CLR:  front_nxt = '0;
      default: front_nxt = front_r;
    endcase
    case (cmd.cnt_op)
      CT_INC:  count_nxt = count_r + 1'b1;
      CT_DEC:  count_nxt = count_r - 1'b1;
      CT_CLR:  count_nxt = '0;
      default: count_nxt = count_r;
    endcase
    if (cmd.pos_clr) begin
      pos_nxt = '0;
    end else if (cmd.pos_inc) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  // result register frees as soon as the sink takes it
  always_comb begin
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      count_r  <= '0;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      front_r  <= front_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      mode_r <= in_mode;
      val_r  <= in_value;
    end
    if (cmd.emit) begin
      ostatus_r <= cmd.emit_status;
      oitem_r   <= cmd.emit_dump ? rd_data_r : '0;
      ocount_r  <= count_r;
      olast_r   <= cmd.emit_dump ? (pos_p1 == count_r) : 1'b1;
    end
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign stat.mode     = mode_t'(mode_r);
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CNT_W'(CAPACITY));
  assign stat.match    = (rd_data_r == val_r);
  assign stat.pos_zero = (pos_r == '0);
  assign stat.pos_last = (pos_p1 == count_r);
  assign stat.out_free = !ovalid_r || out_ready;

  assign out_valid  = ovalid_r;
  assign out_status = ostatus_r;
  assign out_item   = oitem_r;
  assign out_count  = ocount_r;
  assign out_last   = olast_r;

endmodule

>>> rtl/bdq_ctrl.sv
// Controller state machine: sequences each request through execute, search,
// shift and dump steps. Depends on bdq_pkg.
module bdq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bdq_pkg::stat_t  stat,
  output bdq_pkg::cmd_t   cmd
);
  import bdq_pkg::*;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  // next state and held status code
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt    = ST_OK;
        state_nxt = S_EMIT;
        case (stat.mode)
          MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (stat.full) st_nxt = ST_FULL;
          end
          MODE_POP_FRONT, MODE_POP_BACK, MODE_CLEAR: begin
            if (stat.empty) st_nxt = ST_EMPTY;
          end
          MODE_DELETE: begin
            if (stat.empty) st_nxt = ST_EMPTY;
            else            state_nxt = S_SRCH_RD;
          end
          MODE_DUMP: begin
            if (stat.empty) st_nxt = ST_EMPTY;
            else            state_nxt = S_DUMP_RD;
          end
          default: ;
        endcase
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (stat.match) begin
          st_nxt    = ST_OK;
          state_nxt = stat.pos_zero ? S_EMIT : S_SHIFT_RD;
        end else if (stat.pos_last) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SRCH_RD;
        end
      end
      S_SHIFT_RD: state_nxt = stat.pos_last ? S_EMIT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_DUMP_RD:  state_nxt = S_DUMP_EMIT;
      S_DUMP_EMIT: begin
        if (stat.out_free) state_nxt = stat.pos_last ? S_IDLE : S_DUMP_RD;
      end
      S_EMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_POS;
    cmd.wr_sel   = WR_FRONT;
    cmd.front_op = FR_HOLD;
    cmd.cnt_op   = CT_HOLD;
    cmd.emit_status = st_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_op  = in_valid;
      end
      S_EXEC: begin
        cmd.pos_clr = 1'b1;
        case (stat.mode)
          MODE_PUSH_FRONT: begin
            if (!stat.full) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = WR_FRONT;
              cmd.front_op = FR_DEC;
              cmd.cnt_op   = CT_INC;
            end
          end
          MODE_PUSH_BACK: begin
            if (!stat.full) begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_BACK;
              cmd.cnt_op = CT_INC;
            end
          end
          MODE_POP_FRONT: begin
            if (!stat.empty) begin
              cmd.front_op = FR_INC;
              cmd.cnt_op   = CT_DEC;
            end
          end
          MODE_POP_BACK: begin
            if (!stat.empty) cmd.cnt_op = CT_DEC;
          end
          MODE_CLEAR: begin
            cmd.front_op = FR_CLR;
            cmd.cnt_op   = CT_CLR;
          end
          default: ;
        endcase
      end
      S_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_POS;
      end
      S_SRCH_CMP: begin
        if (stat.match) begin
          if (stat.pos_zero) begin
            cmd.front_op = FR_INC;
            cmd.cnt_op   = CT_DEC;
          end
        end else if (!stat.pos_last) begin
          cmd.pos_inc = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        if (stat.pos_last) begin
          cmd.cnt_op = CT_DEC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.pos_inc = 1'b1;
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_POS;
      end
      S_DUMP_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_dump   = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.pos_inc     = !stat.pos_last;
        end
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

>>> rtl/bounded_deque_with_value_delete_unit.sv
// Bounded deque of signed 32-bit values in a 16-entry ring, with delete-by-value
// and dump. Each request is captured, then executed; delete then searches from
// the front and, on a hit past the front, shifts the later entries down; dump
// reads and emits each entry in turn. A result waits while the result register
// is still held by the sink. Requests are handled one at a time; the next is
// taken in the idle state once the last result is written to the result register.
// Sync active-low reset empties the deque (count and front cleared); entry contents are not cleared.
module bounded_deque_with_value_delete_unit (
  input  logic      clk,
  input  logic      rst_n,
  bdq_in_if.sink    in_ch,
  bdq_out_if.source out_ch
);
  import bdq_pkg::*;

  cmd_t  cmd;   // controller commands to the datapath
  stat_t stat;  // datapath flags back to the controller

  // The controller takes a request only in its idle state; the result
  // register in the datapath lets it accept the next request while the
  // last result still waits on the sink.
  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entry store, ring pointers and result register.
  bdq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_mode    (in_ch.mode),
    .in_value   (in_ch.value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_item   (out_ch.item),
    .out_count  (out_ch.count),
    .out_last   (out_ch.last)
  );

endmodule

>>> tb/sv/bdq_reply_checker.sv
// Result checker for the bounded deque unit: watches the request and result
// channels, keeps its own copy of the ring and compares every result.
// Depends on bdq_pkg, bdq_in_if and bdq_out_if.
module bdq_reply_checker (
  input  logic clk,
  input  logic rst_n,
  bdq_in_if    in_ch,
  bdq_out_if   out_ch,
  output int   mismatches,
  output int   owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] item;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } reply_t;

  reply_t                   owed_results[$];
  logic signed [DATA_W-1:0] ring_copy[CAPACITY];
  int                       head_pos;
  int                       held;

  function automatic reply_t make_reply(input status_t st,
                                        input logic signed [DATA_W-1:0] it,
                                        input logic fin);
    reply_t r;
    r.status = st;
    r.item   = it;
    r.count  = CNT_W'(held);
    r.last   = fin;
    return r;
  endfunction

  // Updates the ring copy for one request and queues the results it owes.
  task automatic apply_request(input logic [2:0] op,
                               input logic signed [DATA_W-1:0] v);
    status_t st;
    int      hit;
    st  = ST_OK;
    hit = -1;
    case (op)
      MODE_PUSH_FRONT: begin
        if (held == CAPACITY) begin
          st = ST_FULL;
        end else begin
          head_pos = (head_pos + CAPACITY - 1) % CAPACITY;
          ring_copy[head_pos] = v;
          held++;
        end
      end
      MODE_PUSH_BACK: begin
        if (held == CAPACITY) begin
          st = ST_FULL;
        end else begin
          ring_copy[(head_pos + held) % CAPACITY] = v;
          held++;
        end
      end
      MODE_POP_FRONT: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end else begin
          head_pos = (head_pos + 1) % CAPACITY;
          held--;
        end
      end
      MODE_POP_BACK: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end else begin
          held--;
        end
      end
      MODE_DELETE: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < held; i++) begin
            if (hit < 0 && ring_copy[(head_pos + i) % CAPACITY] == v) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            st = ST_NOT_FOUND;
          end else if (hit == 0) begin
            head_pos = (head_pos + 1) % CAPACITY;
            held--;
          end else begin
            // close the gap toward the front, order kept
            for (int i = hit; i + 1 < held; i++) begin
              ring_copy[(head_pos + i) % CAPACITY] =
                ring_copy[(head_pos + i + 1) % CAPACITY];
            end
            held--;
          end
        end
      end
      MODE_CLEAR: begin
        if (held == 0) begin
          st = ST_EMPTY;
        end
        held     = 0;
        head_pos = 0;
      end
      MODE_DUMP: begin
        if (held == 0) begin
          owed_results.push_back(make_reply(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < held; i++) begin
            owed_results.push_back(make_reply(ST_OK,
                ring_copy[(head_pos + i) % CAPACITY], i + 1 == held));
          end
        end
        return;
      end
      default: begin
      end
    endcase
    owed_results.push_back(make_reply(st, '0, 1'b1));
  endtask

  task automatic check_field(input string fld, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0h got %0h", $time, fld, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      head_pos = 0;
      held     = 0;
      owed_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.mode, in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result expected none got status %0d item %0h",
                   $time, out_ch.status, out_ch.item);
        end else begin
          want = owed_results.pop_front();
          check_field("status", DATA_W'(want.status), DATA_W'(out_ch.status));
          check_field("item", want.item, out_ch.item);
          check_field("count", DATA_W'(want.count), DATA_W'(out_ch.count));
          check_field("last", DATA_W'(want.last), DATA_W'(out_ch.last));
        end
      end
    end
    owed = owed_results.size();
  end

endmodule

>>> tb/sv/tb_bounded_deque_with_value_delete_unit.sv
// Testbench top for bounded_deque_with_value_delete_unit: clock, reset,
// request stimulus, result back-pressure and the verdict.
// Depends on bdq_pkg, bdq_in_if, bdq_out_if and bdq_reply_checker.
module tb_bounded_deque_with_value_delete_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  // mode 7 has no package name; the block must answer it with a plain ok
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam int         RANDOM_REQS = 357;
  localparam int         RECENT_N    = 8;

  // random stretches: fill pushes hard toward full, drain empties, mix roams
  typedef enum {EP_FILL, EP_DRAIN, EP_MIX} episode_t;
  // receiver back-pressure patterns
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   owed;

  bdq_in_if  in_ch();
  bdq_out_if out_ch();

  bounded_deque_with_value_delete_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bdq_reply_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .owed       (owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: ready follows a randomly chosen pattern, held for a random stretch,
  // from wide open to mostly stalled, so stalls land on dump beats.
  rx_pattern_t rx_mode    = RX_OPEN;
  int          rx_left    = 0;
  int          rx_tick    = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(5, 40);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
      default:   out_ch.ready <= rx_tick[1];
    endcase
  end

  // Recently pushed values, so that deletes mostly hit something held.
  logic signed [DATA_W-1:0] recent[RECENT_N];
  int                       recent_wr  = 0;
  int                       burst_left = 0;

  // One request: the sender works in bursts; between bursts valid drops for
  // a random gap (sometimes none). Valid only changes at the falling edge.
  task automatic send_req(input logic [2:0] op, input logic signed [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= op;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (op == MODE_PUSH_FRONT || op == MODE_PUSH_BACK) begin
      recent[recent_wr] = v;
      recent_wr = (recent_wr + 1) % RECENT_N;
    end
  endtask

  // Push values: extremes, a small pool that makes duplicates, full range.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      4, 5:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Delete targets: mostly a recent push (hit), else pool or noise (miss).
  function automatic logic signed [DATA_W-1:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return recent[$urandom_range(0, RECENT_N - 1)];
    end else if (r < 8) begin
      return pick_value();
    end
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(input episode_t ep);
    int r;
    r = $urandom_range(0, 99);
    case (ep)
      EP_FILL: begin
        if (r < 45) return MODE_PUSH_FRONT;
        if (r < 90) return MODE_PUSH_BACK;
        if (r < 97) return MODE_DUMP;
        return MODE_DELETE;
      end
      EP_DRAIN: begin
        if (r < 25) return MODE_POP_FRONT;
        if (r < 50) return MODE_POP_BACK;
        if (r < 75) return MODE_DELETE;
        if (r < 88) return MODE_DUMP;
        if (r < 93) return MODE_PUSH_BACK;
        if (r < 97) return MODE_CLEAR;
        return MODE_UNUSED;
      end
      default: begin
        if (r < 20) return MODE_PUSH_FRONT;
        if (r < 40) return MODE_PUSH_BACK;
        if (r < 50) return MODE_POP_FRONT;
        if (r < 60) return MODE_POP_BACK;
        if (r < 76) return MODE_DELETE;
        if (r < 88) return MODE_DUMP;
        if (r < 93) return MODE_CLEAR;
        return MODE_UNUSED;
      end
    endcase
  endfunction

  initial begin
    episode_t   ep;
    int         ep_len;
    int         sent;
    logic [2:0] op;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = '0;
    in_ch.value  = '0;
    sent         = 0;
    foreach (recent[i]) recent[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: each pop, delete, clear and dump on an empty deque, including unused mode 7
    send_req(MODE_DUMP, '0);
    send_req(MODE_POP_FRONT, '0);
    send_req(MODE_POP_BACK, '0);
    send_req(MODE_DELETE, 5);
    send_req(MODE_CLEAR, '0);
    send_req(MODE_UNUSED, '0);
    // extremes at both ends, then a duplicate so delete takes the first copy
    send_req(MODE_PUSH_FRONT, 32'sh8000_0000);
    send_req(MODE_PUSH_BACK, 32'sh7fff_ffff);
    send_req(MODE_PUSH_FRONT, -1);
    send_req(MODE_PUSH_BACK, '0);
    send_req(MODE_PUSH_BACK, 5);
    send_req(MODE_PUSH_FRONT, 5);
    send_req(MODE_UNUSED, 32'sh5555_aaaa);
    send_req(MODE_DUMP, '0);
    send_req(MODE_DELETE, 5);          // front hit
    send_req(MODE_DELETE, '0);         // middle hit, tail shifts down
    send_req(MODE_DELETE, 1234);       // absent
    send_req(MODE_DUMP, '0);
    send_req(MODE_POP_FRONT, '0);
    send_req(MODE_POP_BACK, '0);
    send_req(MODE_DUMP, '0);
    send_req(MODE_CLEAR, '0);          // clear with entries held
    send_req(MODE_DUMP, '0);

    // Random: first stretch fills past capacity so full pushes show up early
    ep     = EP_FILL;
    ep_len = 24;
    while (sent < RANDOM_REQS) begin
      repeat (ep_len) begin
        if (sent < RANDOM_REQS) begin
          op = pick_op(ep);
          send_req(op, (op == MODE_DELETE) ? pick_target() : pick_value());
          sent++;
        end
      end
      ep     = episode_t'($urandom_range(0, 2));
      ep_len = $urandom_range(8, 30);
    end
    in_ch.valid <= 1'b0;

    // drain: every owed result back, then a quiet spell longer than the
    // slowest delete so a stray extra result would still be caught
    while (owed != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && owed == 0) begin
      $display("bounded_deque_with_value_delete_unit verification clean");
    end else begin
      $display("bounded_deque_with_value_delete_unit verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run (full dumps, long stalls).
  initial begin
    #5_000_000;
    $display("bounded_deque_with_value_delete_unit verification failed");
    $finish;
  end

endmodule
